@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the checker files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge, disabled while reset is low.
`define TTAM_ASSERT_RST(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: assertion failed");

// Checked on every rising edge, reset included.
`define TTAM_ASSERT_ALL(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("%m: assertion failed");

`endif

@@ rtl/ttam_pkg.sv @@
// ----------------------------------------------------------------------------
// ttam_pkg
// Shared constants, register codes and stage control type of the mapper.
// ----------------------------------------------------------------------------
package ttam_pkg;

  localparam int unsigned MAX_RANK_DEF   = 6;
  localparam int unsigned DIM_BITS_DEF   = 10;
  localparam int unsigned INDEX_BITS_DEF = 24;

  localparam int unsigned OFF_W         = 24;
  localparam int unsigned BYTE_W        = 27;
  localparam int unsigned RANK_W        = 3;
  localparam int unsigned EB_W          = 4;
  localparam int unsigned PERM_FIELD_W  = 3;
  localparam int unsigned AXIS_W        = 4;
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned CFG_REG_LIMIT = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RANK       = 3'd0,
    CFG_DIMS       = 3'd1,
    CFG_PERM       = 3'd2,
    CFG_REVERSE    = 3'd3,
    CFG_ELEM_BYTES = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic valid;
    logic ok;
  } stage_ctl_t;

endpackage

@@ rtl/ttam_div_cell.sv @@
// ----------------------------------------------------------------------------
// ttam_div_cell
// One restoring-division step of the index split; the last step of an axis
// scatters the remainder into its input coordinate.
// ----------------------------------------------------------------------------
module ttam_div_cell #(
  parameter int unsigned MAX_RANK   = ttam_pkg::MAX_RANK_DEF,
  parameter int unsigned DIM_BITS   = ttam_pkg::DIM_BITS_DEF,
  parameter int unsigned INDEX_BITS = ttam_pkg::INDEX_BITS_DEF,
  parameter bit          LAST       = 1'b0
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  logic [INDEX_BITS-1:0]        work_i,
  input  logic [DIM_BITS-1:0]          pr_i,
  input  logic [MAX_RANK*DIM_BITS-1:0] coord_i,
  input  logic [MAX_RANK-1:0]          written_i,
  input  logic [DIM_BITS:0]            divisor_i,
  input  logic                         hit_i,
  input  logic [ttam_pkg::AXIS_W-1:0]  perm_i,
  output logic                         valid_o,
  output logic [INDEX_BITS-1:0]        work_o,
  output logic [DIM_BITS-1:0]          pr_o,
  output logic [MAX_RANK*DIM_BITS-1:0] coord_o,
  output logic [MAX_RANK-1:0]          written_o
);

  logic                         valid_q;
  logic [INDEX_BITS-1:0]        work_q, work_d;
  logic [DIM_BITS-1:0]          pr_q, pr_d;
  logic [MAX_RANK*DIM_BITS-1:0] coord_q, coord_d;
  logic [MAX_RANK-1:0]          written_q, written_d;

  logic [DIM_BITS:0]   trial;
  logic [DIM_BITS:0]   diff;
  logic                ge;
  logic [DIM_BITS-1:0] pr_new;

  always_comb begin
    trial     = {pr_i, work_i[INDEX_BITS-1]};
    ge        = (trial >= divisor_i);
    diff      = trial - divisor_i;
    pr_new    = ge ? diff[DIM_BITS-1:0] : trial[DIM_BITS-1:0];
    work_d    = {work_i[INDEX_BITS-2:0], ge};
    pr_d      = pr_new;
    coord_d   = coord_i;
    written_d = written_i;
    if (LAST) begin
      // first writer wins: higher output axes come through earlier
      pr_d = '0;
      for (int k = 0; k < MAX_RANK; k++) begin
        if (hit_i && (perm_i == ttam_pkg::AXIS_W'(k)) && !written_i[k]) begin
          coord_d[k*DIM_BITS +: DIM_BITS] = pr_new;
          written_d[k]                    = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      work_q    <= work_d;
      pr_q      <= pr_d;
      coord_q   <= coord_d;
      written_q <= written_d;
    end
  end

  assign valid_o   = valid_q;
  assign work_o    = work_q;
  assign pr_o      = pr_q;
  assign coord_o   = coord_q;
  assign written_o = written_q;

endmodule

@@ rtl/ttam_horner_cell.sv @@
// ----------------------------------------------------------------------------
// ttam_horner_cell
// One input axis of the offset accumulation: acc = acc * dim + coord.
// ----------------------------------------------------------------------------
module ttam_horner_cell #(
  parameter int unsigned MAX_RANK = ttam_pkg::MAX_RANK_DEF,
  parameter int unsigned DIM_BITS = ttam_pkg::DIM_BITS_DEF,
  parameter int unsigned AXIS     = 0
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  ttam_pkg::stage_ctl_t         ctl_i,
  input  logic [ttam_pkg::OFF_W-1:0]   acc_i,
  input  logic [MAX_RANK*DIM_BITS-1:0] coord_i,
  input  logic [DIM_BITS:0]            dim_i,
  input  logic                         active_i,
  output ttam_pkg::stage_ctl_t         ctl_o,
  output logic [ttam_pkg::OFF_W-1:0]   acc_o,
  output logic [MAX_RANK*DIM_BITS-1:0] coord_o
);

  localparam int unsigned PROD_W = ttam_pkg::OFF_W + DIM_BITS + 1;

  ttam_pkg::stage_ctl_t         ctl_q;
  logic [ttam_pkg::OFF_W-1:0]   acc_q, acc_d;
  logic [MAX_RANK*DIM_BITS-1:0] coord_q;

  logic [PROD_W-1:0]          prod;
  logic [ttam_pkg::OFF_W-1:0] sum;

  always_comb begin
    prod  = PROD_W'(acc_i) * PROD_W'(dim_i);
    sum   = prod[ttam_pkg::OFF_W-1:0]
          + ttam_pkg::OFF_W'(coord_i[AXIS*DIM_BITS +: DIM_BITS]);
    acc_d = active_i ? sum : acc_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      acc_q   <= acc_d;
      coord_q <= coord_i;
    end
  end

  assign ctl_o   = ctl_q;
  assign acc_o   = acc_q;
  assign coord_o = coord_q;

endmodule

@@ rtl/ttam_out_buf.sv @@
// ----------------------------------------------------------------------------
// ttam_out_buf
// Two-entry output buffer; forms the byte offset and zeroes invalid results.
// ----------------------------------------------------------------------------
module ttam_out_buf (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ttam_pkg::stage_ctl_t        ctl_i,
  input  logic [ttam_pkg::OFF_W-1:0]  acc_i,
  input  logic [ttam_pkg::EB_W-1:0]   eb_i,
  output logic                        full_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [ttam_pkg::OFF_W-1:0]  source_offset_o,
  output logic [ttam_pkg::BYTE_W-1:0] source_byte_offset_o,
  output logic                        index_valid_o
);

  localparam int unsigned PROD_W = ttam_pkg::OFF_W + ttam_pkg::EB_W;

  logic [ttam_pkg::OFF_W-1:0]  off_mem  [2];
  logic [ttam_pkg::BYTE_W-1:0] byte_mem [2];
  logic                        ok_mem   [2];

  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q, count_d;

  logic                        push, pop;
  logic [PROD_W-1:0]           prod;
  logic [ttam_pkg::OFF_W-1:0]  off_w;
  logic [ttam_pkg::BYTE_W-1:0] byte_w;

  assign full_o = (count_q == 2'd2);
  assign push   = !full_o && ctl_i.valid;
  assign pop    = out_valid_o && out_ready_i;

  always_comb begin
    prod   = PROD_W'(acc_i) * PROD_W'(eb_i);
    off_w  = ctl_i.ok ? acc_i : '0;
    byte_w = ctl_i.ok ? prod[ttam_pkg::BYTE_W-1:0] : '0;
  end

  always_comb begin
    case ({push, pop})
      2'b10:   count_d = count_q + 2'd1;
      2'b01:   count_d = count_q - 2'd1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      off_mem[wr_ptr_q]  <= off_w;
      byte_mem[wr_ptr_q] <= byte_w;
      ok_mem[wr_ptr_q]   <= ctl_i.ok;
    end
  end

  assign out_valid_o          = (count_q != 2'd0);
  assign source_offset_o      = off_mem[rd_ptr_q];
  assign source_byte_offset_o = byte_mem[rd_ptr_q];
  assign index_valid_o        = ok_mem[rd_ptr_q];

endmodule

@@ rtl/tensor_transpose_address_map.sv @@
// ----------------------------------------------------------------------------
// tensor_transpose_address_map: transposed output index to source offset
// Path: division cells (one per index bit per axis), accumulation cells, output buffer.
// Throughput: one transfer per cycle while the output buffer is not full.
// Reset: clears all stage valid flags and the output buffer; registers take their defaults.
// ----------------------------------------------------------------------------
module tensor_transpose_address_map #(
  parameter int unsigned MAX_RANK   = ttam_pkg::MAX_RANK_DEF,
  parameter int unsigned DIM_BITS   = ttam_pkg::DIM_BITS_DEF,
  parameter int unsigned INDEX_BITS = ttam_pkg::INDEX_BITS_DEF,
  localparam int unsigned DIMS_FULL_W = DIM_BITS * MAX_RANK,
  localparam int unsigned DIMS_W =
    (DIMS_FULL_W > ttam_pkg::CFG_REG_LIMIT) ? ttam_pkg::CFG_REG_LIMIT : DIMS_FULL_W,
  localparam int unsigned PERM_W = ttam_pkg::PERM_FIELD_W * MAX_RANK,
  localparam int unsigned CFG_W0 = (DIMS_W > PERM_W) ? DIMS_W : PERM_W,
  localparam int unsigned CFG_DATA_W = (CFG_W0 > ttam_pkg::EB_W) ? CFG_W0 : ttam_pkg::EB_W
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [ttam_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0]          cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [INDEX_BITS-1:0]          out_index_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [ttam_pkg::OFF_W-1:0]     source_offset_o,
  output logic [ttam_pkg::BYTE_W-1:0]    source_byte_offset_o,
  output logic                           index_valid_o
);

  localparam int unsigned N_DIV = MAX_RANK * INDEX_BITS;
  localparam int unsigned AW    = ttam_pkg::AXIS_W;

  function automatic logic [PERM_W-1:0] identity_perm();
    logic [PERM_W-1:0] v;
    v = '0;
    for (int j = 0; j < MAX_RANK; j++) begin
      v[j*ttam_pkg::PERM_FIELD_W +: ttam_pkg::PERM_FIELD_W] = ttam_pkg::PERM_FIELD_W'(j);
    end
    return v;
  endfunction

  localparam logic [PERM_W-1:0] PERM_RST = identity_perm();

  // configuration registers
  logic [ttam_pkg::RANK_W-1:0] rank_q;
  logic [DIMS_W-1:0]           dims_q;
  logic [PERM_W-1:0]           perm_q;
  logic                        rev_q;
  logic [ttam_pkg::EB_W-1:0]   eb_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rank_q <= ttam_pkg::RANK_W'(1);
      dims_q <= '0;
      perm_q <= PERM_RST;
      rev_q  <= 1'b0;
      eb_q   <= ttam_pkg::EB_W'(1);
    end else if (cfg_valid_i) begin
      case (ttam_pkg::cfg_idx_e'(cfg_index_i))
        ttam_pkg::CFG_RANK:       rank_q <= cfg_data_i[ttam_pkg::RANK_W-1:0];
        ttam_pkg::CFG_DIMS:       dims_q <= cfg_data_i[DIMS_W-1:0];
        ttam_pkg::CFG_PERM:       perm_q <= cfg_data_i[PERM_W-1:0];
        ttam_pkg::CFG_REVERSE:    rev_q  <= cfg_data_i[0];
        ttam_pkg::CFG_ELEM_BYTES: eb_q   <= cfg_data_i[ttam_pkg::EB_W-1:0];
        default: ;
      endcase
    end
  end

  // effective rank, clamped to 1..MAX_RANK
  logic [AW-1:0] r_eff;

  always_comb begin
    if (rank_q == '0) begin
      r_eff = AW'(1);
    end else if ({1'b0, rank_q} > AW'(MAX_RANK)) begin
      r_eff = AW'(MAX_RANK);
    end else begin
      r_eff = {1'b0, rank_q};
    end
  end

  // input dimension sizes; fields past the register width read as size 1
  logic [DIMS_FULL_W-1:0] dims_ext;
  logic [DIM_BITS:0]      dim_size [MAX_RANK];

  assign dims_ext = DIMS_FULL_W'(dims_q);

  for (genvar k = 0; k < MAX_RANK; k++) begin : g_dim
    assign dim_size[k] = (DIM_BITS+1)'(dims_ext[k*DIM_BITS +: DIM_BITS]) + (DIM_BITS+1)'(1);
  end

  // per output axis: source axis, hit flag, divisor
  logic [AW-1:0]     axis_perm [MAX_RANK];
  logic              axis_hit  [MAX_RANK];
  logic [DIM_BITS:0] axis_div  [MAX_RANK];

  for (genvar j = 0; j < MAX_RANK; j++) begin : g_axis
    always_comb begin
      if (rev_q) begin
        axis_perm[j] = r_eff - AW'(j + 1);
      end else begin
        axis_perm[j] = AW'(perm_q[j*ttam_pkg::PERM_FIELD_W +: ttam_pkg::PERM_FIELD_W]);
      end
      axis_hit[j] = (AW'(j) < r_eff) && (axis_perm[j] < r_eff);
      axis_div[j] = (DIM_BITS+1)'(1);
      for (int k = 0; k < MAX_RANK; k++) begin
        if (axis_hit[j] && (axis_perm[j] == AW'(k))) begin
          axis_div[j] = dim_size[k];
        end
      end
    end
  end

  // pipeline advance: hold everything while the output buffer is full
  logic adv;
  logic buf_full;

  assign adv        = !buf_full;
  assign in_ready_o = adv;

  // division chain: output axes from highest to lowest, one quotient bit per cell
  logic                   dv_valid   [N_DIV+1];
  logic [INDEX_BITS-1:0]  dv_work    [N_DIV+1];
  logic [DIM_BITS-1:0]    dv_pr      [N_DIV+1];
  logic [DIMS_FULL_W-1:0] dv_coord   [N_DIV+1];
  logic [MAX_RANK-1:0]    dv_written [N_DIV+1];

  assign dv_valid[0]   = in_valid_i;
  assign dv_work[0]    = out_index_i;
  assign dv_pr[0]      = '0;
  assign dv_coord[0]   = '0;
  assign dv_written[0] = '0;

  for (genvar s = 0; s < N_DIV; s++) begin : g_div
    localparam int unsigned AXIS = MAX_RANK - 1 - s / INDEX_BITS;
    localparam bit          LAST = ((s % INDEX_BITS) == INDEX_BITS - 1);

    ttam_div_cell #(
      .MAX_RANK   (MAX_RANK),
      .DIM_BITS   (DIM_BITS),
      .INDEX_BITS (INDEX_BITS),
      .LAST       (LAST)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .en_i      (adv),
      .valid_i   (dv_valid[s]),
      .work_i    (dv_work[s]),
      .pr_i      (dv_pr[s]),
      .coord_i   (dv_coord[s]),
      .written_i (dv_written[s]),
      .divisor_i (axis_div[AXIS]),
      .hit_i     (axis_hit[AXIS]),
      .perm_i    (axis_perm[AXIS]),
      .valid_o   (dv_valid[s+1]),
      .work_o    (dv_work[s+1]),
      .pr_o      (dv_pr[s+1]),
      .coord_o   (dv_coord[s+1]),
      .written_o (dv_written[s+1])
    );
  end

  // accumulation chain over input axes; a nonzero final quotient marks an
  // index beyond the element count
  ttam_pkg::stage_ctl_t       h_ctl   [MAX_RANK+1];
  logic [ttam_pkg::OFF_W-1:0] h_acc   [MAX_RANK+1];
  logic [DIMS_FULL_W-1:0]     h_coord [MAX_RANK+1];

  assign h_ctl[0].valid = dv_valid[N_DIV];
  assign h_ctl[0].ok    = (dv_work[N_DIV] == '0);
  assign h_acc[0]       = '0;
  assign h_coord[0]     = dv_coord[N_DIV];

  for (genvar i = 0; i < MAX_RANK; i++) begin : g_acc
    ttam_horner_cell #(
      .MAX_RANK (MAX_RANK),
      .DIM_BITS (DIM_BITS),
      .AXIS     (i)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (adv),
      .ctl_i    (h_ctl[i]),
      .acc_i    (h_acc[i]),
      .coord_i  (h_coord[i]),
      .dim_i    (dim_size[i]),
      .active_i (AW'(i) < r_eff),
      .ctl_o    (h_ctl[i+1]),
      .acc_o    (h_acc[i+1]),
      .coord_o  (h_coord[i+1])
    );
  end

  ttam_out_buf u_out_buf (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .ctl_i                (h_ctl[MAX_RANK]),
    .acc_i                (h_acc[MAX_RANK]),
    .eb_i                 (eb_q),
    .full_o               (buf_full),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .source_offset_o      (source_offset_o),
    .source_byte_offset_o (source_byte_offset_o),
    .index_valid_o        (index_valid_o)
  );

endmodule

@@ rtl/ttam_checker.sv @@
// ----------------------------------------------------------------------------
// ttam_checker
// Port-level checks on the result channel and input backpressure.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ttam_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_ready_o,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [ttam_pkg::OFF_W-1:0]  source_offset_o,
  input logic [ttam_pkg::BYTE_W-1:0] source_byte_offset_o,
  input logic                        index_valid_o
);

  // a stalled result stays offered
  `TTAM_ASSERT_RST(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o)

  // a stalled result keeps its payload
  `TTAM_ASSERT_RST(a_out_stable, clk_i, rst_ni, out_valid_o && !out_ready_i |=> $stable(source_offset_o) && $stable(source_byte_offset_o) && $stable(index_valid_o))

  // an out-of-range index carries zero offsets
  `TTAM_ASSERT_RST(a_invalid_zero, clk_i, rst_ni, out_valid_o && !index_valid_o |-> source_offset_o == '0 && source_byte_offset_o == '0)

  // input stalls only when finished results are waiting
  `TTAM_ASSERT_ALL(a_stall_cause, clk_i, !in_ready_o |-> out_valid_o)

endmodule

bind tensor_transpose_address_map ttam_checker u_ttam_checker (.*);

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: tensor transpose address map
// Sends output indices under a series of tensor shapes, permutations and
// element sizes, predicts source element and byte offsets for every accepted
// index, and checks each returned transfer in order against the prediction.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned MAX_RANK      = ttam_pkg::MAX_RANK_DEF;
  localparam int unsigned DIM_BITS      = ttam_pkg::DIM_BITS_DEF;
  localparam int unsigned INDEX_BITS    = ttam_pkg::INDEX_BITS_DEF;
  localparam int unsigned OFF_W         = ttam_pkg::OFF_W;
  localparam int unsigned BYTE_W        = ttam_pkg::BYTE_W;
  localparam int unsigned RANK_W        = ttam_pkg::RANK_W;
  localparam int unsigned EB_W          = ttam_pkg::EB_W;
  localparam int unsigned PERM_FIELD_W  = ttam_pkg::PERM_FIELD_W;
  localparam int unsigned CFG_IDX_W     = ttam_pkg::CFG_IDX_W;
  localparam int unsigned DIMS_W        = DIM_BITS * MAX_RANK;
  localparam int unsigned PERM_W        = PERM_FIELD_W * MAX_RANK;
  localparam int unsigned CFG_DATA_W    = DIMS_W;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd6;
  localparam logic [PERM_W-1:0] PERM_IDENTITY = 18'd181896;
  localparam longint unsigned INDEX_SPAN = 64'd1 << INDEX_BITS;
  localparam int unsigned RANDOM_ITEMS  = 1730;
  localparam int unsigned SETTLE_CYCLES = 200;
  localparam int unsigned CYCLE_LIMIT   = 800000;

  typedef struct packed {
    logic [OFF_W-1:0]  src_offset;
    logic [BYTE_W-1:0] src_bytes;
    logic              in_range;
  } src_addr_t;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  logic [INDEX_BITS-1:0] out_index_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [OFF_W-1:0]      source_offset_o;
  logic [BYTE_W-1:0]     source_byte_offset_o;
  logic                  index_valid_o;

  // Register copies as the block holds them
  logic [RANK_W-1:0] cur_rank       = 3'd1;
  logic [DIMS_W-1:0] cur_dims       = '0;
  logic [PERM_W-1:0] cur_perm       = PERM_IDENTITY;
  logic              cur_reverse    = 1'b0;
  logic [EB_W-1:0]   cur_elem_bytes = 4'd1;

  src_addr_t   pending_addrs[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned rx_hold = 0;
  bit          tx_calm = 1'b0;
  bit          rx_calm = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  tensor_transpose_address_map u_top (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_valid_i          (cfg_valid_i),
    .cfg_ready_o          (cfg_ready_o),
    .cfg_index_i          (cfg_index_i),
    .cfg_data_i           (cfg_data_i),
    .in_valid_i           (in_valid_i),
    .in_ready_o           (in_ready_o),
    .out_index_i          (out_index_i),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .source_offset_o      (source_offset_o),
    .source_byte_offset_o (source_byte_offset_o),
    .index_valid_o        (index_valid_o)
  );

  function automatic int unsigned used_rank();
    if (cur_rank == 0) return 1;
    if (cur_rank > MAX_RANK) return MAX_RANK;
    return 32'(cur_rank);
  endfunction

  function automatic longint unsigned in_dim(int unsigned axis);
    return 64'(cur_dims[axis*DIM_BITS +: DIM_BITS]) + 64'd1;
  endfunction

  // Input axis read by output axis j, or -1 where the entry is out of range
  function automatic int src_axis(int unsigned j, int unsigned r);
    int unsigned p;
    p = cur_reverse ? r - 1 - j : 32'(cur_perm[j*PERM_FIELD_W +: PERM_FIELD_W]);
    return (p < r) ? int'(p) : -1;
  endfunction

  function automatic longint unsigned out_dim(int unsigned j, int unsigned r);
    int a;
    a = src_axis(j, r);
    return (a < 0) ? 64'd1 : in_dim(a);
  endfunction

  function automatic longint unsigned elem_count();
    int unsigned     r;
    longint unsigned total;
    r = used_rank();
    total = 1;
    for (int unsigned j = 0; j < r; j++) begin
      total *= out_dim(j, r);
      if (total > INDEX_SPAN) total = INDEX_SPAN;
    end
    return total;
  endfunction

  function automatic src_addr_t map_index(logic [INDEX_BITS-1:0] idx);
    src_addr_t       res;
    int unsigned     r;
    int              a;
    longint unsigned rem, stride, off, bytes;
    longint unsigned i_coord [MAX_RANK];
    longint unsigned o_coord [MAX_RANK];
    res = '0;
    if (64'(idx) >= elem_count()) return res;
    r = used_rank();
    rem = 64'(idx);
    for (int j = int'(r) - 1; j >= 0; j--) begin
      o_coord[j] = rem % out_dim(j, r);
      rem = rem / out_dim(j, r);
    end
    for (int j = 0; j < MAX_RANK; j++) i_coord[j] = 0;
    // Scatter upward so a repeated input axis keeps the higher output axis
    for (int j = 0; j < int'(r); j++) begin
      a = src_axis(j, r);
      if (a >= 0) i_coord[a] = o_coord[j];
    end
    stride = 1;
    off = 0;
    for (int j = int'(r) - 1; j >= 0; j--) begin
      off += i_coord[j] * stride;
      stride *= in_dim(j);
    end
    res.src_offset = off[OFF_W-1:0];
    bytes = 64'(res.src_offset) * 64'(cur_elem_bytes);
    res.src_bytes = bytes[BYTE_W-1:0];
    res.in_range = 1'b1;
    return res;
  endfunction

  always @(posedge clk_i) begin : check_results
    src_addr_t want;
    src_addr_t got;
    got = {source_offset_o, source_byte_offset_o, index_valid_o};
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_addrs.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("[%0t] transfer with nothing pending: offset %0d bytes %0d valid %0b",
                   $time, got.src_offset, got.src_bytes, got.in_range);
      end else begin
        want = pending_addrs.pop_front();
        if (got.src_offset !== want.src_offset || got.src_bytes !== want.src_bytes ||
            got.in_range !== want.in_range) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("[%0t] mismatch exp/act: offset %0d/%0d bytes %0d/%0d valid %0b/%0b",
                     $time, want.src_offset, got.src_offset, want.src_bytes, got.src_bytes,
                     want.in_range, got.in_range);
        end
      end
    end
  end

  // Result side stalls: mostly short, now and then long
  always @(posedge clk_i) begin
    if (rx_hold != 0) begin
      rx_hold--;
      out_ready_i <= 1'b0;
    end else if (!rx_calm && $urandom_range(0, 9) < 3) begin
      rx_hold = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 29) : $urandom_range(0, 2);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic int unsigned draw_gap();
    int unsigned roll;
    if (tx_calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  // Valid stays high back to back; drop it only ahead of a gap
  task automatic send_index(input logic [INDEX_BITS-1:0] idx);
    int unsigned gap;
    gap = draw_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    out_index_i <= idx;
    do @(posedge clk_i); while (!in_ready_o);
    pending_addrs = {pending_addrs, map_index(idx)};
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_addrs.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] which,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= which;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (which)
      ttam_pkg::CFG_RANK:       cur_rank       = value[RANK_W-1:0];
      ttam_pkg::CFG_DIMS:       cur_dims       = value[DIMS_W-1:0];
      ttam_pkg::CFG_PERM:       cur_perm       = value[PERM_W-1:0];
      ttam_pkg::CFG_REVERSE:    cur_reverse    = value[0];
      ttam_pkg::CFG_ELEM_BYTES: cur_elem_bytes = value[EB_W-1:0];
      default: ;
    endcase
  endtask

  task automatic program_regs(input logic [RANK_W-1:0] rank, input logic [DIMS_W-1:0] dims,
                              input logic [PERM_W-1:0] perm, input logic reverse,
                              input logic [EB_W-1:0] elem_bytes);
    logic [CFG_DATA_W-1:0] junk;
    wait_drained();
    // Upper data bits beyond each register must be dropped
    junk = ($urandom_range(0, 3) == 0) ? CFG_DATA_W'({$urandom, $urandom}) : '0;
    write_reg(ttam_pkg::CFG_RANK, {junk[CFG_DATA_W-1:RANK_W], rank});
    write_reg(ttam_pkg::CFG_DIMS, dims);
    write_reg(ttam_pkg::CFG_PERM, {junk[CFG_DATA_W-1:PERM_W], perm});
    write_reg(ttam_pkg::CFG_REVERSE, {junk[CFG_DATA_W-1:1], reverse});
    write_reg(ttam_pkg::CFG_ELEM_BYTES, {junk[CFG_DATA_W-1:EB_W], elem_bytes});
    cfg_valid_i <= 1'b0;
  endtask

  task automatic randomize_regs();
    logic [RANK_W-1:0] rank;
    logic [DIMS_W-1:0] dims;
    logic [PERM_W-1:0] perm;
    logic [EB_W-1:0]   elem_bytes;
    int unsigned       order [MAX_RANK];
    int unsigned       r, k, tmp, roll;
    roll = $urandom_range(0, 19);
    if (roll == 0) rank = 3'd0;
    else if (roll == 1) rank = 3'd7;
    else rank = 3'($urandom_range(1, MAX_RANK));
    if ($urandom_range(0, 7) == 0) begin
      dims = DIMS_W'({$urandom, $urandom});
    end else begin
      for (int j = 0; j < MAX_RANK; j++) begin
        roll = $urandom_range(0, 19);
        if (roll < 14) dims[j*DIM_BITS +: DIM_BITS] = 10'($urandom_range(0, 7));
        else if (roll < 18) dims[j*DIM_BITS +: DIM_BITS] = 10'($urandom_range(0, 63));
        else dims[j*DIM_BITS +: DIM_BITS] = 10'($urandom_range(0, 1023));
      end
    end
    r = (rank == 0) ? 1 : ((rank > MAX_RANK) ? MAX_RANK : 32'(rank));
    for (int j = 0; j < MAX_RANK; j++) order[j] = j;
    for (int j = int'(r) - 1; j > 0; j--) begin
      k = $urandom_range(0, j);
      tmp = order[j];
      order[j] = order[k];
      order[k] = tmp;
    end
    perm = PERM_W'($urandom);
    if ($urandom_range(0, 5) != 0)
      for (int j = 0; j < int'(r); j++) perm[j*PERM_FIELD_W +: PERM_FIELD_W] = 3'(order[j]);
    elem_bytes = ($urandom_range(0, 5) == 0) ? 4'($urandom_range(0, 15))
                                             : 4'($urandom_range(1, 8));
    program_regs(rank, dims, perm, ($urandom_range(0, 3) == 0), elem_bytes);
  endtask

  function automatic logic [INDEX_BITS-1:0] pick_index();
    longint unsigned cnt;
    int unsigned     roll;
    cnt = elem_count();
    roll = $urandom_range(0, 19);
    if (roll < 14) return INDEX_BITS'($urandom_range(0, 32'(cnt - 1)));
    if (roll < 17) return INDEX_BITS'(cnt - 2 + 64'($urandom_range(0, 3)));
    return INDEX_BITS'($urandom);
  endfunction

  task automatic test_reset_defaults();
    send_index('0);
    send_index(INDEX_BITS'(1));
    send_index('1);
  endtask

  // Input shape (3,4,5), output axes read input axes 2,0,1: output (5,3,4)
  task automatic test_fixed_shape();
    program_regs(3'd3, {10'd0, 10'd0, 10'd0, 10'd4, 10'd3, 10'd2},
                 {3'd0, 3'd0, 3'd0, 3'd1, 3'd0, 3'd2}, 1'b0, 4'd4);
    send_index(INDEX_BITS'(0));
    send_index(INDEX_BITS'(59));
    send_index(INDEX_BITS'(60));
    send_index(INDEX_BITS'(37));
  endtask

  // Full rank at maximum sizes: the count clips, every index is in range
  task automatic test_reverse_saturated();
    program_regs(3'd6, '1, PERM_W'($urandom), 1'b1, 4'd8);
    send_index('0);
    send_index('1);
    send_index(INDEX_BITS'($urandom));
  endtask

  task automatic test_rank_limits();
    // rank zero behaves as one; zero element size zeroes the byte offset
    program_regs(3'd0, {50'({$urandom, $urandom}), 10'd1023}, PERM_IDENTITY, 1'b0, 4'd0);
    send_index(INDEX_BITS'(5));
    send_index(INDEX_BITS'(1023));
    send_index(INDEX_BITS'(1024));
    // rank above the maximum, repeated and out-of-range permutation entries
    program_regs(3'd7, {10'd4, 10'd1, 10'd3, 10'd2, 10'd0, 10'd5},
                 {3'd2, 3'd6, 3'd0, 3'd1, 3'd1, 3'd7}, 1'b0, 4'd15);
    send_index(INDEX_BITS'(0));
    send_index(INDEX_BITS'(elem_count() - 1));
    send_index(INDEX_BITS'($urandom_range(0, 32'(elem_count() - 1))));
  endtask

  task automatic test_unused_register();
    wait_drained();
    write_reg(CFG_SPARE, CFG_DATA_W'({$urandom, $urandom}));
    cfg_valid_i <= 1'b0;
    send_index(INDEX_BITS'($urandom_range(0, 32'(elem_count() - 1))));
    send_index(INDEX_BITS'(elem_count()));
  endtask

  task automatic test_random_traffic();
    int unsigned sent;
    int unsigned burst;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      randomize_regs();
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm <= ($urandom_range(0, 3) == 0);
      burst = $urandom_range(40, 110);
      repeat (burst) begin
        // hold the sender off until the pipe is empty
        if ($urandom_range(0, 79) == 0) wait_drained();
        send_index(pick_index());
        sent++;
      end
    end
    tx_calm = 1'b0;
    rx_calm <= 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_fixed_shape();
    test_reverse_saturated();
    test_rank_limits();
    test_unused_register();
    test_random_traffic();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && pending_addrs.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/ttam_pkg.sv
rtl/ttam_div_cell.sv
rtl/ttam_horner_cell.sv
rtl/ttam_out_buf.sv
rtl/tensor_transpose_address_map.sv
rtl/ttam_checker.sv
verif/testbench.sv
